FILE: rtl/dual_stack_shared_array_assert.svh
// Assertion macros for the two-stack block.
// Depends on nothing; taken in by the top level with `include.
`ifndef DUAL_STACK_SHARED_ARRAY_ASSERT_SVH
`define DUAL_STACK_SHARED_ARRAY_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DSSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dual stack check failed");

// Next-cycle implication, held off during reset.
`define DSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dual stack check failed");

`endif

FILE: rtl/dssa_pkg.sv
// Shared constants, codes and inter-module structs of the two-stack block.
// Depends on nothing; imported by every module of the block.
package dssa_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_ONE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TWO = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_ONE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TWO  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST_ONE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST_TWO = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic                     valid;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     valid;
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } res_t;

endpackage

FILE: rtl/dssa_front.sv
// Front end: takes commands, drops unused codes, holds them in a short queue.
// Depends on dssa_pkg.
module dssa_front import dssa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [WORD_W-1:0] in_push_value,
  output cmd_t                     cq_head,
  input  logic                     cq_take
);

  logic [CMD_W-1:0]         cq_cmd_r [CQ_DEPTH];
  logic signed [WORD_W-1:0] cq_val_r [CQ_DEPTH];
  logic [CQ_AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0]         cnt_r, cnt_nxt;
  logic                     known;
  logic                     wr_en;
  logic                     rd_en;

  always_comb begin
    unique case (in_command) inside
      CMD_PUSH_ONE, CMD_PUSH_TWO, CMD_POP_ONE,
      CMD_POP_TWO, CMD_LIST_ONE, CMD_LIST_TWO: known = 1'b1;
      default:                                 known = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign wr_en   = in_push && !in_full && known;
  assign rd_en   = cq_take && (cnt_r != '0);

  assign cq_head.valid = (cnt_r != '0);
  assign cq_head.cmd   = cq_cmd_r[rd_ptr_r];
  assign cq_head.value = cq_val_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cq_cmd_r[wr_ptr_r] <= in_command;
      cq_val_r[wr_ptr_r] <= in_push_value;
    end
  end

endmodule

FILE: rtl/dssa_back.sv
// Back end: word store, stack counts, list walker and read pipeline stage.
// Depends on dssa_pkg; fed by dssa_front, drains into dssa_outq.
module dssa_back import dssa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cq_head,
  output logic             cq_take,
  input  logic [OQ_CW-1:0] oq_cnt,
  output res_t             res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;
  localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  logic          st_r, st_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic [AW-1:0] walk_addr_r, walk_addr_nxt;
  logic [CW-1:0] walk_left_r, walk_left_nxt;
  logic          walk_up_r, walk_up_nxt;

  logic              pipe_v_r;
  logic [STAT_W-1:0] pipe_status_r;
  logic              pipe_last_r;
  logic              pipe_mem_r;

  logic [OQ_CW:0]           occ;
  logic                     room;
  logic [CW:0]              used;
  logic                     store_full;
  logic                     issue;
  logic [STAT_W-1:0]        is_status;
  logic                     is_last;
  logic                     is_mem;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [WORD_W-1:0] wdata;
  logic                     re;
  logic [AW-1:0]            raddr;

  // room counts the entry already in the read stage
  assign occ  = {1'b0, oq_cnt} + (OQ_CW + 1)'(pipe_v_r);
  assign room = (occ < (OQ_CW + 1)'(OQ_DEPTH));
  assign used = {1'b0, low_r} + {1'b0, high_r};
  assign store_full = (used >= (CW + 1)'(DEPTH));

  always_comb begin
    st_nxt        = st_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    walk_addr_nxt = walk_addr_r;
    walk_left_nxt = walk_left_r;
    walk_up_nxt   = walk_up_r;
    cq_take       = 1'b0;
    issue         = 1'b0;
    is_status     = STAT_OK;
    is_last       = 1'b1;
    is_mem        = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = cq_head.value;
    re            = 1'b0;
    raddr         = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (cq_head.valid && room) begin
          cq_take = 1'b1;
          unique case (cq_head.cmd)
            CMD_PUSH_ONE: begin
              issue = 1'b1;
              if (store_full) begin
                is_status = STAT_OVERFLOW;
              end else begin
                we      = 1'b1;
                waddr   = low_r[AW-1:0];
                low_nxt = low_r + 1'b1;
              end
            end
            CMD_PUSH_TWO: begin
              issue = 1'b1;
              if (store_full) begin
                is_status = STAT_OVERFLOW;
              end else begin
                we       = 1'b1;
                waddr    = TOP_ADDR - high_r[AW-1:0];
                high_nxt = high_r + 1'b1;
              end
            end
            CMD_POP_ONE: begin
              issue = 1'b1;
              if (low_r == '0) begin
                is_status = STAT_EMPTY;
              end else begin
                low_nxt = low_r - 1'b1;
                re      = 1'b1;
                raddr   = low_nxt[AW-1:0];
                is_mem  = 1'b1;
              end
            end
            CMD_POP_TWO: begin
              issue = 1'b1;
              if (high_r == '0) begin
                is_status = STAT_EMPTY;
              end else begin
                high_nxt = high_r - 1'b1;
                re       = 1'b1;
                raddr    = TOP_ADDR - high_nxt[AW-1:0];
                is_mem   = 1'b1;
              end
            end
            CMD_LIST_ONE: begin
              if (low_r == '0) begin
                issue     = 1'b1;
                is_status = STAT_EMPTY;
              end else begin
                st_nxt        = ST_WALK;
                walk_addr_nxt = '0;
                walk_left_nxt = low_r;
                walk_up_nxt   = 1'b1;
              end
            end
            CMD_LIST_TWO: begin
              if (high_r == '0) begin
                issue     = 1'b1;
                is_status = STAT_EMPTY;
              end else begin
                st_nxt        = ST_WALK;
                walk_addr_nxt = TOP_ADDR;
                walk_left_nxt = high_r;
                walk_up_nxt   = 1'b0;
              end
            end
            default: begin
              issue = 1'b0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (room) begin
          issue         = 1'b1;
          re            = 1'b1;
          raddr         = walk_addr_r;
          is_mem        = 1'b1;
          is_last       = (walk_left_r == CW'(1));
          walk_left_nxt = walk_left_r - 1'b1;
          walk_addr_nxt = walk_up_r ? walk_addr_r + 1'b1 : walk_addr_r - 1'b1;
          if (is_last) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      low_r    <= '0;
      high_r   <= '0;
      pipe_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pipe_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    walk_addr_r   <= walk_addr_nxt;
    walk_left_r   <= walk_left_nxt;
    walk_up_r     <= walk_up_nxt;
    pipe_status_r <= is_status;
    pipe_last_r   <= is_last;
    pipe_mem_r    <= is_mem;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign res.valid  = pipe_v_r;
  assign res.status = pipe_status_r;
  assign res.value  = pipe_mem_r ? rd_data_r : '0;
  assign res.last   = pipe_last_r;

endmodule

FILE: rtl/dssa_outq.sv
// Result queue: holds finished results until the consumer pops them.
// Depends on dssa_pkg; fed by dssa_back.
module dssa_outq import dssa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  res_t                     res,
  output logic [OQ_CW-1:0]         oq_cnt,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_value,
  output logic                     out_last
);

  logic [STAT_W-1:0]        stat_r [OQ_DEPTH];
  logic signed [WORD_W-1:0] val_r  [OQ_DEPTH];
  logic                     last_r [OQ_DEPTH];
  logic [OQ_AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0]         cnt_r, cnt_nxt;
  logic                     rd_en;

  assign out_empty  = (cnt_r == '0);
  assign rd_en      = out_pop && !out_empty;
  assign oq_cnt     = cnt_r;
  assign out_status = stat_r[rd_ptr_r];
  assign out_value  = val_r[rd_ptr_r];
  assign out_last   = last_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (res.valid) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (res.valid && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !res.valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      stat_r[wr_ptr_r] <= res.status;
      val_r[wr_ptr_r]  <= res.value;
      last_r[wr_ptr_r] <= res.last;
    end
  end

endmodule

FILE: rtl/dual_stack_shared_array.sv
// Top level of the two-stack block: front queue, execution back end, result queue.
// Depends on dssa_pkg, dssa_front, dssa_back, dssa_outq and the assertion header.
//
//   channel   | handshake        | payload
//   ----------+------------------+-----------------------------------------
//   command   | in_push/in_full  | in_command[2:0], in_push_value[31:0]
//   result    | out_pop/out_empty| out_status[1:0], out_value[31:0], out_last
//
// A push or pop result enters the result queue in the cycle after the back end
// takes the command, the result being registered in the read stage; from the
// input it passes the command queue and then the read stage.
// A list keeps the back end in its walk state until every entry has been read.
// Synchronous active-low reset clears counts and queues; the store is not cleared.
// A full result queue stalls the back end, and the command queue fills behind it.
module dual_stack_shared_array import dssa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_value,
  output logic                     out_last
);

  `include "dual_stack_shared_array_assert.svh"

  cmd_t             cq_head;
  logic             cq_take;
  res_t             res;
  logic [OQ_CW-1:0] oq_cnt;

  // front: accept and classify, drop unused codes
  dssa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_push_value (in_push_value),
    .cq_head       (cq_head),
    .cq_take       (cq_take)
  );

  // back: carry commands out against the store, holding on result-queue room
  dssa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cq_head (cq_head),
    .cq_take (cq_take),
    .oq_cnt  (oq_cnt),
    .res     (res)
  );

  // result queue towards the consumer
  dssa_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .oq_cnt     (oq_cnt),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  // a result leaving the read stage always finds a free slot
  `DSSA_ASSERT_NOW(a_oq_room, clk, rst_n, res.valid, oq_cnt < OQ_CW'(OQ_DEPTH))
  // overflow and empty results close their command and carry no word
  `DSSA_ASSERT_NOW(a_err_last, clk, rst_n,
    res.valid && (res.status == STAT_OVERFLOW || res.status == STAT_EMPTY),
    res.last && res.value == '0)
  // an accepted command is still queued in the cycle after
  `DSSA_ASSERT_NEXT(a_cmd_held, clk, rst_n,
    in_push && !in_full && in_command <= CMD_LIST_TWO, cq_head.valid)

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for dual_stack_shared_array: two stacks sharing one word store.
// Depends on dssa_pkg and the dual_stack_shared_array RTL; drives commands, checks every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dssa_pkg::*;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // Kinds of random segment
  localparam int SEG_FILL  = 0;
  localparam int SEG_MIXED = 1;
  localparam int SEG_DRAIN = 2;

  localparam int unsigned RANDOM_ITEMS = 420;
  // Worst case: ~470 items, each a 64-word list, each result behind the longest receiver stall.
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;
  // Longest list walk plus pipeline, with margin.
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } result_rec_t;

  // Tracks both stacks and the results each accepted command must produce.
  class dual_stack_tracker;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned              depth_one;
    int unsigned              depth_two;
    result_rec_t              owed [$];
    int unsigned              mismatches;

    function void owe(logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] v, logic lst);
      result_rec_t r;
      r.status = st;
      r.value  = v;
      r.last   = lst;
      owed.push_back(r);
    endfunction

    function bit store_full();
      return (depth_one + depth_two) >= DEPTH;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] val);
      int unsigned i;
      case (cmd)
        CMD_PUSH_ONE: begin
          if (store_full()) begin
            owe(STAT_OVERFLOW, '0, 1'b1);
          end else begin
            words[depth_one] = val;
            depth_one++;
            owe(STAT_OK, '0, 1'b1);
          end
        end
        CMD_PUSH_TWO: begin
          if (store_full()) begin
            owe(STAT_OVERFLOW, '0, 1'b1);
          end else begin
            words[DEPTH - 1 - depth_two] = val;
            depth_two++;
            owe(STAT_OK, '0, 1'b1);
          end
        end
        CMD_POP_ONE: begin
          if (depth_one == 0) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            depth_one--;
            owe(STAT_OK, words[depth_one], 1'b1);
          end
        end
        CMD_POP_TWO: begin
          if (depth_two == 0) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            depth_two--;
            owe(STAT_OK, words[DEPTH - 1 - depth_two], 1'b1);
          end
        end
        CMD_LIST_ONE: begin
          if (depth_one == 0) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < depth_one; i++)
              owe(STAT_OK, words[i], (i + 1) == depth_one);
          end
        end
        CMD_LIST_TWO: begin
          if (depth_two == 0) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < depth_two; i++)
              owe(STAT_OK, words[DEPTH - 1 - i], (i + 1) == depth_two);
          end
        end
        default: ;  // spare codes: no result, no state change
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] v,
                               logic lst);
      result_rec_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result status %0d value %08h last %0b", st, v, lst));
        return;
      end
      want = owed.pop_front();
      if (st !== want.status || v !== want.value || lst !== want.last)
        report($sformatf("expected status %0d value %08h last %0b, got %0d %08h %0b",
                         want.status, want.value, want.last, st, v, lst));
    endfunction

    function void close();
      if (owed.size() != 0)
        report($sformatf("%0d results never arrived", owed.size()));
    endfunction
  endclass

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_push       = 1'b0;
  logic                     in_full;
  logic [CMD_W-1:0]         in_command    = '0;
  logic signed [WORD_W-1:0] in_push_value = '0;
  logic                     out_empty;
  logic                     out_pop       = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_value;
  logic                     out_last;

  dual_stack_tracker tracker = new();

  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 1;
  int unsigned random_items = 0;
  int unsigned pop_run_left = 0;
  logic        pop_level    = 1'b0;

  dual_stack_shared_array i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_push_value (in_push_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake must never stall the run forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: alternate runs of popping and stalling; now and then a long
  // free-flowing stretch so the block runs at full rate.
  always @(posedge clk) begin
    if (pop_run_left == 0) begin
      pop_level = ~pop_level;
      if (pop_level)
        pop_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
      else
        pop_run_left = $urandom_range(1, 12);
    end
    pop_run_left--;
    out_pop <= pop_level;
  end

  // Result monitor: a transfer happens on an edge with pop high and empty low.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      tracker.check_result(out_status, out_value, out_last);
  end

  // Offer one command and hold it until the transfer; then, at the end of a
  // burst, drop push for a random gap and scramble the payload meanwhile.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [WORD_W-1:0] val);
    in_push       <= 1'b1;
    in_command    <= cmd;
    in_push_value <= val;
    do @(posedge clk); while (in_full);
    tracker.note_command(cmd, val);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      in_push       <= 1'b0;
      in_command    <= CMD_W'($urandom);
      in_push_value <= $urandom;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Hold the sender off until every owed result has been popped.
  task automatic pause_until_drained();
    if (in_push)
      in_push <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // One random segment. Fill pushes until the store overflows a few times,
  // drain pops until both stacks report empty a few times, mixed is uniform.
  // Lists and spare codes are sprinkled through all of them.
  task automatic random_segment(input int seg);
    int unsigned              one_bias;
    int unsigned              extra;
    int unsigned              span;
    int unsigned              steps;
    int unsigned              roll;
    logic                     side_one;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] val;
    logic signed [WORD_W-1:0] corner [4];
    corner[0] = 32'sh8000_0000;
    corner[1] = 32'sh7fff_ffff;
    corner[2] = '0;
    corner[3] = -32'sd1;
    case ($urandom_range(0, 2))
      0:       one_bias = 0;
      1:       one_bias = 100;
      default: one_bias = $urandom_range(10, 90);
    endcase
    extra = $urandom_range(1, 3);
    span  = $urandom_range(20, 40);
    steps = 0;
    while (1) begin
      side_one = ($urandom_range(1, 100) <= one_bias);
      roll     = $urandom_range(1, 100);
      if (roll <= 4) begin
        cmd = roll[0] ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if (roll <= 10) begin
        cmd = side_one ? CMD_LIST_ONE : CMD_LIST_TWO;
      end else begin
        case (seg)
          SEG_FILL: begin
            cmd = side_one ? CMD_PUSH_ONE : CMD_PUSH_TWO;
            if (tracker.store_full())
              extra--;
          end
          SEG_DRAIN: begin
            if (roll > 85) begin
              cmd = side_one ? CMD_PUSH_ONE : CMD_PUSH_TWO;
            end else begin
              if (tracker.depth_one == 0 && tracker.depth_two == 0) begin
                cmd = side_one ? CMD_POP_ONE : CMD_POP_TWO;
                extra--;
              end else if (tracker.depth_one == 0) begin
                cmd = CMD_POP_TWO;
              end else if (tracker.depth_two == 0) begin
                cmd = CMD_POP_ONE;
              end else begin
                cmd = $urandom_range(0, 1) ? CMD_POP_ONE : CMD_POP_TWO;
              end
            end
          end
          default: cmd = CMD_W'($urandom_range(0, 5));
        endcase
      end
      val = ($urandom_range(0, 7) == 0) ? corner[$urandom_range(0, 3)] : $urandom;
      send_command(cmd, val);
      if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7)
        random_items++;
      steps++;
      // stop as soon as enough items have gone in
      if (random_items >= RANDOM_ITEMS)
        break;
      if (seg == SEG_MIXED ? (steps >= span) : (extra == 0))
        break;
    end
  endtask

  initial begin
    // Synchronous reset held low from the start, released at an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stacks, extreme words on both sides, lists, spare codes,
    // pops back down to empty.
    send_command(CMD_POP_ONE,  '0);
    send_command(CMD_POP_TWO,  '0);
    send_command(CMD_LIST_ONE, '0);
    send_command(CMD_LIST_TWO, '0);
    send_command(CMD_PUSH_ONE, 32'sh7fff_ffff);
    send_command(CMD_PUSH_ONE, 32'sh8000_0000);
    send_command(CMD_PUSH_TWO, '0);
    send_command(CMD_PUSH_TWO, -32'sd1);
    send_command(CMD_PUSH_ONE, 32'sh5555_5555);
    send_command(CMD_PUSH_TWO, 32'shaaaa_aaaa);
    send_command(CMD_LIST_ONE, '0);
    send_command(CMD_LIST_TWO, '0);
    send_command(CMD_SPARE_6,  32'sh1234_5678);
    send_command(CMD_SPARE_7,  -32'sd1);
    send_command(CMD_POP_ONE,  '0);
    send_command(CMD_POP_TWO,  '0);
    send_command(CMD_LIST_ONE, '0);
    send_command(CMD_LIST_TWO, '0);
    send_command(CMD_POP_ONE,  '0);
    send_command(CMD_POP_ONE,  '0);
    send_command(CMD_POP_ONE,  '0);
    send_command(CMD_POP_TWO,  '0);
    send_command(CMD_POP_TWO,  '0);
    send_command(CMD_POP_TWO,  '0);

    // Let the pipeline empty completely before the random part.
    pause_until_drained();

    // Random: fill to overflow, churn, drain to empty; repeat until enough
    // items have gone in, pausing for a full drain now and then.
    while (random_items < RANDOM_ITEMS) begin
      random_segment(SEG_FILL);
      random_segment(SEG_MIXED);
      if ($urandom_range(0, 2) == 0)
        pause_until_drained();
      random_segment(SEG_DRAIN);
    end

    // Stop sending, wait for the last results, then watch for strays.
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.close();
    if (tracker.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
